@@ rtl/waveform_oscillator_with_release_assert.svh @@
// Assertion macros for the oscillator checker.
`ifndef WAVEFORM_OSCILLATOR_WITH_RELEASE_ASSERT_SVH
`define WAVEFORM_OSCILLATOR_WITH_RELEASE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WOR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oscillator check failed");

// The consequent must hold in the cycle after the antecedent.
`define WOR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oscillator check failed");

// Checked also while reset is applied.
`define WOR_ASSERT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("oscillator check failed");

`endif

@@ rtl/wor_pkg.sv @@
// Package: types, codes, constants and lookup tables of the oscillator.
package wor_pkg;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int EXP_TABLE_DEPTH  = 256;
    localparam int SINE_AW = $clog2(SINE_TABLE_DEPTH);
    localparam int EXP_AW  = $clog2(EXP_TABLE_DEPTH);

    localparam longint unsigned PI_Q28 = 64'd843314857;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_ON    = 2'd1;
    localparam logic [1:0] CMD_OFF   = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic [2:0] WF_SINE     = 3'd0;
    localparam logic [2:0] WF_SQUARE   = 3'd1;
    localparam logic [2:0] WF_SAW_UP   = 3'd2;
    localparam logic [2:0] WF_SAW_DOWN = 3'd3;
    localparam logic [2:0] WF_TRIANGLE = 3'd4;

    localparam logic [2:0] REG_WAVEFORM    = 3'd0;
    localparam logic [2:0] REG_AMPLITUDE   = 3'd1;
    localparam logic [2:0] REG_START_PHASE = 3'd2;
    localparam logic [2:0] REG_RELEASE_LEN = 3'd3;
    localparam logic [2:0] REG_FADE_LEN    = 3'd4;

    localparam logic [1:0] DIV_WAVE = 2'd0;
    localparam logic [1:0] DIV_ENV  = 2'd1;
    localparam logic [1:0] DIV_EXP  = 2'd2;

    localparam logic [1:0] MUL_AG  = 2'd0;
    localparam logic [1:0] MUL_EX  = 2'd1;
    localparam logic [1:0] MUL_M   = 2'd2;
    localparam logic [1:0] MUL_MAG = 2'd3;

    localparam int DIV_STEP_W = 5;
    localparam logic [DIV_STEP_W-1:0] WAVE_STEPS = 5'd18;
    localparam logic [DIV_STEP_W-1:0] ENV_STEPS  = 5'd16;
    localparam logic [DIV_STEP_W-1:0] EXP_STEPS  = DIV_STEP_W'(EXP_AW + 1);

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] period;
        logic [15:0] gain;
    } t_in;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               voice_done;
    } t_out;

    typedef struct packed {
        logic       accept;
        logic       div_start;
        logic [1:0] div_sel;
        logic       lat_wave;
        logic       lat_env;
        logic       lat_k;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic silent;
        logic rel_item;
        logic need_exp;
        logic div_done;
        logic out_free;
    } t_sts;

    typedef logic signed [15:0] t_sine_tab [SINE_TABLE_DEPTH];
    typedef logic [15:0]        t_exp_tab  [EXP_TABLE_DEPTH];

    // Shift and subtract quotient, used only while the tables are built.
    function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            r = (r << 1) | ((a >> i) & 64'd1);
            q = q << 1;
            if (r >= b) begin
                r = r - b;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    function automatic t_sine_tab build_sine();
        t_sine_tab         tab;
        longint unsigned   x;
        longint unsigned   t;
        longint            sum;
        longint            q;
        bit                neg;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            x = (64'd2 * PI_Q28 * longint'(i)) >> SINE_AW;
            neg = 1'b0;
            if (x >= PI_Q28) begin
                x = x - PI_Q28;
                neg = 1'b1;
            end
            if (x > (PI_Q28 >> 1)) x = PI_Q28 - x;
            sum = longint'(x);
            t = x;
            for (int n = 1; n <= 12; n++) begin
                t = (t * x) >> 28;
                t = (t * x) >> 28;
                t = udiv64(t, longint'(2 * n) * longint'(2 * n + 1));
                if ((n & 1) == 1) sum = sum - longint'(t);
                else sum = sum + longint'(t);
            end
            if (sum < 0) sum = 0;
            q = (sum * 32768 + (longint'(1) << 27)) >>> 28;
            if (q > 32767) q = 32767;
            tab[i] = neg ? 16'(-q) : 16'(q);
        end
        return tab;
    endfunction

    function automatic t_exp_tab build_exp();
        t_exp_tab        tab;
        longint unsigned y;
        longint unsigned sum;
        longint unsigned t;
        bit              stop;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            y = ((64'd10 * longint'(k)) << 20) >> EXP_AW;
            sum = 64'd1 << 20;
            t = 64'd1 << 20;
            stop = 1'b0;
            for (int n = 1; n < 64; n++) begin
                if (!stop) begin
                    t = udiv64((t * y) >> 20, longint'(n));
                    if (t == 0) stop = 1'b1;
                    else sum = sum + t;
                end
            end
            tab[k] = 16'(udiv64((64'd1 << 35) + (sum >> 1), sum));
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();
    localparam t_exp_tab  EXP_TAB  = build_exp();

endpackage

@@ rtl/wor_div.sv @@
// Shared restoring divider: one quotient bit per cycle of floor(a * 2^(n-1) / d).
module wor_div
    import wor_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [20:0]           i_a,
    input  logic [20:0]           i_d,
    input  logic [DIV_STEP_W-1:0] i_steps,
    output logic                  o_done,
    output logic [17:0]           o_q
);

    logic [21:0]           r_rem;
    logic [20:0]           r_d;
    logic [17:0]           r_q;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic                  ge;
    logic [21:0]           diff;
    logic [20:0]           n_rem;

    always_comb begin
        ge    = r_rem >= {1'b0, r_d};
        diff  = r_rem - {1'b0, r_d};
        n_rem = ge ? diff[20:0] : r_rem[20:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_a};
            r_d   <= i_d;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= {n_rem, 1'b0};
            r_q   <= {r_q[16:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

@@ rtl/wor_dpath.sv @@
// Datapath: configuration, voice state, waveform, envelope, scaling and output register.
module wor_dpath
    import wor_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  t_in         i_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data
);

    logic [2:0]  r_waveform;
    logic [14:0] r_amp;
    logic [15:0] r_sp;
    logic [19:0] r_rl;
    logic [19:0] r_fl;

    logic [15:0] r_phase;
    logic [20:0] r_rc;
    logic        r_voice_on;
    logic        r_releasing;

    logic [15:0] r_j;
    logic [15:0] r_p;
    logic [15:0] r_gain;
    logic [20:0] r_r;
    logic [20:0] r_total;
    logic        r_silent;
    logic        r_rel_item;
    logic        r_need_exp;

    logic        r_vneg;
    logic [15:0] r_vmag;
    logic [15:0] r_m;
    logic [15:0] r_env;
    logic [15:0] r_expv;
    logic [17:0] r_mag;
    logic        r_ov;
    t_out        r_out;

    logic [20:0] total;
    logic [15:0] p_eff;
    logic        n_vo;
    logic        n_rel;
    logic [15:0] n_pc;
    logic [20:0] n_rc;
    logic [15:0] j_use;

    logic [20:0]           div_a;
    logic [20:0]           div_d;
    logic [DIV_STEP_W-1:0] div_steps;
    logic                  div_done;
    logic [17:0]           div_q;

    logic [15:0]        q16;
    logic [15:0]        f;
    logic [SINE_AW-1:0] sidx;
    logic               lt;
    logic signed [18:0] v;
    logic signed [18:0] vabs;
    logic [EXP_AW-1:0]  k;

    logic [15:0] mul_a;
    logic [15:0] mul_b;
    logic [31:0] prod;
    logic [32:0] prod_r;
    logic [17:0] mul_res;

    t_out out_val;
    logic out_free;

    assign total = 21'(r_rl) + 21'(r_fl);

    always_comb begin
        p_eff = (i_data.period < 16'd2) ? 16'd2 : i_data.period;
        n_vo  = r_voice_on;
        n_rel = r_releasing;
        n_pc  = r_phase;
        n_rc  = r_rc;
        if (i_data.command == CMD_ON) begin
            n_vo  = 1'b1;
            n_rel = 1'b0;
            n_pc  = '0;
            n_rc  = '0;
        end else if (i_data.command == CMD_OFF && n_vo && !n_rel) begin
            n_rel = 1'b1;
            n_rc  = '0;
        end
        if (n_vo && n_rel && n_rc >= total) begin
            n_vo  = 1'b0;
            n_rel = 1'b0;
        end
        j_use = (n_pc >= p_eff) ? 16'd0 : n_pc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform <= WF_SINE;
            r_amp      <= 15'd32767;
            r_sp       <= '0;
            r_rl       <= '0;
            r_fl       <= 20'd9600;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WAVEFORM:    r_waveform <= i_cfg_data[2:0];
                REG_AMPLITUDE:   r_amp      <= i_cfg_data[14:0];
                REG_START_PHASE: r_sp       <= i_cfg_data[15:0];
                REG_RELEASE_LEN: r_rl       <= i_cfg_data;
                REG_FADE_LEN:    r_fl       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_rc        <= '0;
            r_voice_on  <= 1'b0;
            r_releasing <= 1'b0;
            r_silent    <= 1'b1;
            r_rel_item  <= 1'b0;
            r_need_exp  <= 1'b0;
        end else if (i_cmd.accept) begin
            r_voice_on  <= n_vo;
            r_releasing <= n_rel;
            r_silent    <= !n_vo;
            r_rel_item  <= n_rel;
            r_need_exp  <= n_rel && (n_rc > 21'(r_rl)) && (r_fl != 20'd0);
            if (n_vo) begin
                r_phase <= j_use + 16'd1;
                r_rc    <= n_rel ? n_rc + 21'd1 : n_rc;
            end else begin
                r_phase <= n_pc;
                r_rc    <= n_rc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_j     <= j_use;
            r_p     <= p_eff;
            r_gain  <= i_data.gain;
            r_r     <= n_rc;
            r_total <= total;
        end
    end

    always_comb begin
        case (i_cmd.div_sel)
            DIV_ENV: begin
                div_a     = r_total - r_r;
                div_d     = r_total;
                div_steps = ENV_STEPS;
            end
            DIV_EXP: begin
                div_a     = r_r - 21'(r_rl);
                div_d     = 21'(r_fl);
                div_steps = EXP_STEPS;
            end
            default: begin
                div_a     = 21'(r_j);
                div_d     = 21'(r_p);
                div_steps = WAVE_STEPS;
            end
        endcase
    end

    wor_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_a     (div_a),
        .i_d     (div_d),
        .i_steps (div_steps),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    always_comb begin
        q16  = div_q[16:1];
        f    = q16 + r_sp;
        sidx = f[15 -: SINE_AW];
        lt   = r_j < (r_p >> 1);
        case (r_waveform)
            WF_SINE:     v = 19'(SINE_TAB[sidx]);
            WF_SQUARE:   v = lt ? 19'sd32768 : -19'sd32768;
            WF_SAW_UP:   v = $signed({3'b000, q16}) - 19'sd32768;
            WF_SAW_DOWN: v = 19'sd32768 - $signed({3'b000, q16});
            WF_TRIANGLE: v = lt ? $signed({1'b0, div_q}) - 19'sd32768
                                : 19'sd98304 - $signed({1'b0, div_q});
            default:     v = '0;
        endcase
        vabs = v[18] ? -v : v;
        k = (div_q >= 18'(EXP_TABLE_DEPTH)) ? EXP_AW'(EXP_TABLE_DEPTH - 1)
                                            : div_q[EXP_AW-1:0];
    end

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_AG: begin
                mul_a = {1'b0, r_amp};
                mul_b = r_gain;
            end
            MUL_EX: begin
                mul_a = r_env;
                mul_b = r_expv;
            end
            MUL_M: begin
                mul_a = r_m;
                mul_b = r_env;
            end
            default: begin
                mul_a = r_vmag;
                mul_b = r_m;
            end
        endcase
        prod    = mul_a * mul_b;
        prod_r  = {1'b0, prod} + 33'd16384;
        mul_res = prod_r[32:15];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_env <= 16'd32768;
        else if (i_cmd.lat_env) r_env <= div_q[15:0];
        else if (i_cmd.mul_en && i_cmd.mul_sel == MUL_EX) r_env <= mul_res[15:0];
        if (i_cmd.lat_wave) begin
            r_vneg <= v[18];
            r_vmag <= vabs[15:0];
        end
        if (i_cmd.lat_k) r_expv <= EXP_TAB[k];
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel) inside
                MUL_AG, MUL_M: r_m   <= mul_res[15:0];
                MUL_MAG:       r_mag <= mul_res;
                default: ;
            endcase
        end
    end

    always_comb begin
        out_val = '0;
        if (r_silent) begin
            out_val.voice_done = 1'b1;
        end else if (r_vneg) begin
            out_val.sample = (r_mag > 18'd32768) ? 16'sh8000 : $signed(16'(-r_mag));
        end else begin
            out_val.sample = (r_mag > 18'd32767) ? 16'sh7FFF : $signed(r_mag[15:0]);
        end
    end

    assign out_free = !r_ov || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) r_out <= out_val;
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

    assign o_sts.silent   = r_silent;
    assign o_sts.rel_item = r_rel_item;
    assign o_sts.need_exp = r_need_exp;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = out_free;

endmodule

@@ rtl/wor_ctrl.sv @@
// Controller: sequences division, multiplication and output steps for each item.
module wor_ctrl
    import wor_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_WDIV  = 4'd2;
    localparam logic [3:0] S_M1    = 4'd3;
    localparam logic [3:0] S_EDIV  = 4'd4;
    localparam logic [3:0] S_KDIV  = 4'd5;
    localparam logic [3:0] S_EX    = 4'd6;
    localparam logic [3:0] S_M2    = 4'd7;
    localparam logic [3:0] S_M3    = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_valid;
                if (i_valid) n_state = S_DISP;
            end
            S_DISP: begin
                if (i_sts.silent) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_WAVE;
                    n_state = S_WDIV;
                end
            end
            S_WDIV: begin
                o_cmd.div_sel = DIV_WAVE;
                if (i_sts.div_done) begin
                    o_cmd.lat_wave = 1'b1;
                    n_state = S_M1;
                end
            end
            S_M1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_AG;
                if (i_sts.rel_item) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_ENV;
                    n_state = S_EDIV;
                end else begin
                    n_state = S_M2;
                end
            end
            S_EDIV: begin
                o_cmd.div_sel = DIV_ENV;
                if (i_sts.div_done) begin
                    o_cmd.lat_env = 1'b1;
                    if (i_sts.need_exp) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = DIV_EXP;
                        n_state = S_KDIV;
                    end else begin
                        n_state = S_M2;
                    end
                end
            end
            S_KDIV: begin
                o_cmd.div_sel = DIV_EXP;
                if (i_sts.div_done) begin
                    o_cmd.lat_k = 1'b1;
                    n_state = S_EX;
                end
            end
            S_EX: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_EX;
                n_state = S_M2;
            end
            S_M2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_M;
                n_state = S_M3;
            end
            S_M3: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_MAG;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = r_state != S_IDLE;

endmodule

@@ rtl/waveform_oscillator_with_release.sv @@
// Top level of the one-voice oscillator with release envelope.
//
//   Port group   Direction  Flow control   Contents
//   input item   in         i_valid/o_stall command, period, gain
//   result item  out        o_valid/i_stall sample, voice_done
//   config       in         i_cfg_we        register index and data
//
// One item is in flight at a time. A silent voice skips division and multiplication;
// a playing voice divides for phase and scales, plus a ramp division while releasing
// and a fade index division in the fade. The shared bit-serial divider takes 18, 16
// and 9 steps for phase, ramp and fade. Reset is synchronous and needs no clearing pass.
// A result waiting under stall does not hold up the next transfer in until it is due.
module waveform_oscillator_with_release
    import wor_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    wor_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    wor_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_data     (i_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

endmodule

@@ rtl/wor_checker.sv @@
// Port-level checker of the oscillator, bound to the top level.
`include "waveform_oscillator_with_release_assert.svh"

module wor_port_checker
    import wor_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input t_out        o_data
);

    `WOR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `WOR_ASSERT_NOW(a_done_silent, i_clk, i_rst_n, o_valid && o_data.voice_done, o_data.sample == '0)
    `WOR_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `WOR_ASSERT_RST(a_rst_clears, i_clk, !i_rst_n, !o_valid && !o_stall)

endmodule

bind waveform_oscillator_with_release wor_port_checker u_wor_port_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
